// ===== rtl/ppab_pkg.sv =====
// ----------------------------------------------------------------------------
// ppab_pkg
// Shared types and constants of the pixel point average buffer.
// ----------------------------------------------------------------------------
package ppab_pkg;

  localparam int unsigned COL_W    = 9;
  localparam int unsigned ROW_W    = 9;
  localparam int unsigned PIX_AW   = COL_W + ROW_W;
  localparam int unsigned SIZE_W   = 10;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned PT_W     = 32;
  localparam int unsigned CH_W     = 8;
  localparam int unsigned SUM_W    = 40;
  localparam int unsigned CSUM_W   = 16;
  localparam int unsigned LANES    = 6;
  localparam int unsigned STEP_W   = 6;
  localparam int unsigned DIV_STEPS = SUM_W;
  localparam logic [CNT_W-1:0] MAX_COUNT = 8'd255;

  localparam int unsigned IN_W  = 144;
  localparam int unsigned OUT_W = 136;

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_ADD  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_RANGE   = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_FULL    = 3'd3,
    ST_NOCOLOR = 3'd4
  } status_e;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_COLOR  = 2'd2;

  // One memory word per pixel.
  typedef struct packed {
    logic [CSUM_W-1:0] csum_r;
    logic [CSUM_W-1:0] csum_g;
    logic [CSUM_W-1:0] csum_b;
    logic [SUM_W-1:0]  sum_z;
    logic [SUM_W-1:0]  sum_y;
    logic [SUM_W-1:0]  sum_x;
    logic [CNT_W-1:0]  cnt;
  } pix_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/pixel_point_average_buffer.sv =====
// ----------------------------------------------------------------------------
// pixel_point_average_buffer
// Per-pixel store of summed points, summed colors and hit counts with
// set, add and average-read operations.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  s_axis    in         tvalid/tready             operation item (144 bits)
//  m_axis    out        tvalid/tready             result item (136 bits)
//  apb       in/out     psel/penable/pwrite       width, height, color enable
//
// Set and add pass through accept, memory read, write back and hand over.
// A read of a filled pixel also passes through the shared six-lane divider,
// which retires one quotient bit per cycle and then flags done.
// After reset a clearing pass zeroes all 262144 counts, one per cycle, with
// s_axis_tready low; configuration writes are taken during it.
// A finished result waits in the output register; the next item is accepted
// meanwhile, and only a second finished result stalls on m_axis_tready.
// ----------------------------------------------------------------------------
module pixel_point_average_buffer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // opcode, column, row, point_x, point_y, point_z, blue_in, green_in,
  // red_in from bit 0 up, zero fill to 144 bits
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [ppab_pkg::IN_W-1:0]  s_axis_tdata,
  // status, mean_x, mean_y, mean_z, mean_blue, mean_green, mean_red,
  // hit_count from bit 0 up, zero fill to 136 bits
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [ppab_pkg::OUT_W-1:0] m_axis_tdata,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EXEC,
    S_DIV,
    S_OUT
  } state_e;

  state_e state_q;

  // configuration
  logic [ppab_pkg::SIZE_W-1:0] width_q, height_q;
  logic                        color_q;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 10'd512;
      height_q <= 10'd512;
      color_q  <= 1'b1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        ppab_pkg::REG_WIDTH:  width_q  <= pwdata[ppab_pkg::SIZE_W-1:0];
        ppab_pkg::REG_HEIGHT: height_q <= pwdata[ppab_pkg::SIZE_W-1:0];
        ppab_pkg::REG_COLOR:  color_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      ppab_pkg::REG_WIDTH:  prdata = {22'd0, width_q};
      ppab_pkg::REG_HEIGHT: prdata = {22'd0, height_q};
      ppab_pkg::REG_COLOR:  prdata = {31'd0, color_q};
      default:              prdata = '0;
    endcase
  end

  // input unpack
  logic in_acc;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  // captured item
  logic [1:0]                  op_q;
  logic [ppab_pkg::PIX_AW-1:0] addr_q;
  logic                        oor_q;
  logic [ppab_pkg::PT_W-1:0]   px_q, py_q, pz_q;
  logic [ppab_pkg::CH_W-1:0]   cb_q, cg_q, cr_q;

  logic                        oor_in;
  assign oor_in = (s_axis_tdata[1:0] == ppab_pkg::OP_NONE)
                | ({1'b0, s_axis_tdata[10:2]}  >= width_q)
                | ({1'b0, s_axis_tdata[19:11]} >= height_q);

  // pixel memory
  ppab_pkg::pix_t              mem [2**ppab_pkg::PIX_AW];
  ppab_pkg::pix_t              rd_q;
  ppab_pkg::pix_t              wr_data;
  logic                        wr_en;
  logic [ppab_pkg::PIX_AW-1:0] wr_addr;
  logic [ppab_pkg::PIX_AW-1:0] clr_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (state_q == S_READ) begin
      rd_q <= mem[addr_q];
    end
  end

  // execute step
  ppab_pkg::pix_t              ex_data;
  logic                        ex_wr;
  logic                        ex_div;
  logic [2:0]                  ex_status;
  logic [ppab_pkg::CNT_W-1:0]  ex_cnt;
  logic [ppab_pkg::SUM_W-1:0]  sx, sy, sz;

  assign sx = {{8{px_q[31]}}, px_q};
  assign sy = {{8{py_q[31]}}, py_q};
  assign sz = {{8{pz_q[31]}}, pz_q};

  always_comb begin
    ex_data   = rd_q;
    ex_wr     = 1'b0;
    ex_div    = 1'b0;
    ex_status = ppab_pkg::ST_OK;
    ex_cnt    = '0;
    if (oor_q) begin
      ex_status = ppab_pkg::ST_RANGE;
    end else if (op_q == ppab_pkg::OP_SET ||
                 (op_q == ppab_pkg::OP_ADD && rd_q.cnt == '0)) begin
      // overwrite with a single point
      ex_wr          = 1'b1;
      ex_data.cnt    = 8'd1;
      ex_data.sum_x  = sx;
      ex_data.sum_y  = sy;
      ex_data.sum_z  = sz;
      ex_data.csum_b = color_q ? {8'd0, cb_q} : '0;
      ex_data.csum_g = color_q ? {8'd0, cg_q} : '0;
      ex_data.csum_r = color_q ? {8'd0, cr_q} : '0;
      ex_cnt         = 8'd1;
    end else if (op_q == ppab_pkg::OP_ADD) begin
      if (rd_q.cnt >= ppab_pkg::MAX_COUNT) begin
        ex_status = ppab_pkg::ST_FULL;
        ex_cnt    = rd_q.cnt;
      end else begin
        ex_wr         = 1'b1;
        ex_data.cnt   = rd_q.cnt + 1'b1;
        ex_data.sum_x = rd_q.sum_x + sx;
        ex_data.sum_y = rd_q.sum_y + sy;
        ex_data.sum_z = rd_q.sum_z + sz;
        if (color_q) begin
          ex_data.csum_b = rd_q.csum_b + {8'd0, cb_q};
          ex_data.csum_g = rd_q.csum_g + {8'd0, cg_q};
          ex_data.csum_r = rd_q.csum_r + {8'd0, cr_q};
        end
        ex_status = color_q ? ppab_pkg::ST_OK : ppab_pkg::ST_NOCOLOR;
        ex_cnt    = rd_q.cnt + 1'b1;
      end
    end else begin
      // average read
      if (rd_q.cnt == '0) begin
        ex_status = ppab_pkg::ST_EMPTY;
      end else begin
        ex_div    = 1'b1;
        ex_status = color_q ? ppab_pkg::ST_OK : ppab_pkg::ST_NOCOLOR;
        ex_cnt    = rd_q.cnt;
      end
    end
  end

  always_comb begin
    if (state_q == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_q;
      wr_data = '0;
    end else begin
      wr_en   = (state_q == S_EXEC) & ex_wr;
      wr_addr = addr_q;
      wr_data = ex_data;
    end
  end

  // divider
  ppab_pkg::div_stat_t div_stat;
  logic [ppab_pkg::LANES-1:0][ppab_pkg::SUM_W-1:0] div_num;
  logic [ppab_pkg::LANES-1:0][ppab_pkg::PT_W-1:0]  div_quot;
  logic                                            div_start;

  assign div_start  = (state_q == S_EXEC) & ex_div;
  assign div_num[0] = rd_q.sum_x;
  assign div_num[1] = rd_q.sum_y;
  assign div_num[2] = rd_q.sum_z;
  assign div_num[3] = {24'd0, rd_q.csum_b};
  assign div_num[4] = {24'd0, rd_q.csum_g};
  assign div_num[5] = {24'd0, rd_q.csum_r};

  ppab_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_num),
    .divisor_i (rd_q.cnt),
    .stat_o    (div_stat),
    .quot_o    (div_quot)
  );

  // pending result and output register
  logic [ppab_pkg::OUT_W-1:0] res_q;
  logic                       out_valid_q;
  logic [ppab_pkg::OUT_W-1:0] out_data_q;
  logic                       out_load;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  // hand over once the output register is free
  assign out_load      = (state_q == S_OUT) & (!out_valid_q | m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          state_q <= ex_div ? S_DIV : S_OUT;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= s_axis_tdata[1:0];
      addr_q <= {s_axis_tdata[19:11], s_axis_tdata[10:2]};
      oor_q  <= oor_in;
      px_q   <= s_axis_tdata[51:20];
      py_q   <= s_axis_tdata[83:52];
      pz_q   <= s_axis_tdata[115:84];
      cb_q   <= s_axis_tdata[123:116];
      cg_q   <= s_axis_tdata[131:124];
      cr_q   <= s_axis_tdata[139:132];
    end
    if (state_q == S_EXEC) begin
      res_q <= {5'd0, ex_cnt, 24'd0, 96'd0, ex_status};
    end else if (state_q == S_DIV && div_stat.done) begin
      res_q[98:3] <= {div_quot[2], div_quot[1], div_quot[0]};
      if (color_q) begin
        res_q[122:99] <= {div_quot[5][7:0], div_quot[4][7:0], div_quot[3][7:0]};
      end
    end
    if (out_load) begin
      out_data_q <= res_q;
    end
  end

  // checks
  a_no_accept_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("item accepted in back-to-back cycles");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == S_DIV)
    else $error("divider finished outside the divide state");

  a_empty_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[2:0] == ppab_pkg::ST_EMPTY) |-> m_axis_tdata[130:123] == '0)
    else $error("empty pixel result carries a count");

  a_no_write_on_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && oor_q) |-> !wr_en)
    else $error("memory written for an out-of-range item");

endmodule

// ===== rtl/ppab_div.sv =====
// ----------------------------------------------------------------------------
// ppab_div
// Six-lane restoring divider: signed 40-bit sums by an 8-bit count, one
// quotient bit per lane each cycle, truncated toward zero.
// ----------------------------------------------------------------------------
module ppab_div (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  input  logic [ppab_pkg::LANES-1:0][ppab_pkg::SUM_W-1:0] dividend_i,
  input  logic [ppab_pkg::CNT_W-1:0]              divisor_i,
  output ppab_pkg::div_stat_t                     stat_o,
  output logic [ppab_pkg::LANES-1:0][ppab_pkg::PT_W-1:0]  quot_o
);

  logic                         busy_q;
  logic                         done_q;
  logic [ppab_pkg::STEP_W-1:0]  step_q;
  logic [ppab_pkg::CNT_W-1:0]   div_q;
  logic [ppab_pkg::LANES-1:0]   neg_q;
  logic [ppab_pkg::LANES-1:0][ppab_pkg::SUM_W-1:0] mag_q;
  logic [ppab_pkg::LANES-1:0][ppab_pkg::CNT_W-1:0] rem_q;
  logic [ppab_pkg::LANES-1:0][ppab_pkg::SUM_W-1:0] mag_d;
  logic [ppab_pkg::LANES-1:0][ppab_pkg::CNT_W-1:0] rem_d;

  always_comb begin
    logic [ppab_pkg::CNT_W:0] trial;
    logic                     ge;
    for (int l = 0; l < ppab_pkg::LANES; l++) begin
      trial    = {rem_q[l], mag_q[l][ppab_pkg::SUM_W-1]};
      ge       = (trial >= {1'b0, div_q});
      rem_d[l] = ge ? ppab_pkg::CNT_W'(trial - {1'b0, div_q}) : trial[ppab_pkg::CNT_W-1:0];
      mag_d[l] = {mag_q[l][ppab_pkg::SUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == ppab_pkg::STEP_W'(ppab_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      for (int l = 0; l < ppab_pkg::LANES; l++) begin
        neg_q[l] <= dividend_i[l][ppab_pkg::SUM_W-1];
        mag_q[l] <= dividend_i[l][ppab_pkg::SUM_W-1] ? -dividend_i[l] : dividend_i[l];
        rem_q[l] <= '0;
      end
    end else if (busy_q) begin
      mag_q <= mag_d;
      rem_q <= rem_d;
    end
  end

  always_comb begin
    for (int l = 0; l < ppab_pkg::LANES; l++) begin
      quot_o[l] = neg_q[l] ? -mag_q[l][ppab_pkg::PT_W-1:0] : mag_q[l][ppab_pkg::PT_W-1:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ===== tb/ppab_scoreboard.sv =====
// ----------------------------------------------------------------------------
// ppab_scoreboard
// Watches the operation, result and register channels of the pixel point
// average buffer, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module ppab_scoreboard (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  input  logic [ppab_pkg::IN_W-1:0]  s_axis_tdata,
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic [ppab_pkg::OUT_W-1:0] m_axis_tdata,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [31:0]                pwdata,
  input  logic                       pready,
  output int                         errors_o,
  output int                         pending_o
);

  typedef struct packed {
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [31:0]       pz;
    logic [31:0]       py;
    logic [31:0]       px;
    logic [8:0]        row;
    logic [8:0]        col;
    ppab_pkg::opcode_e op;
  } op_item_t;

  typedef struct packed {
    logic [7:0]        hits;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [31:0]       mz;
    logic [31:0]       my;
    logic [31:0]       mx;
    ppab_pkg::status_e st;
  } mean_item_t;

  // pixel state, keyed by row * 512 + col
  bit [7:0]  hit_mem[int];
  longint    sum_x[int], sum_y[int], sum_z[int];
  bit [15:0] sum_b[int], sum_g[int], sum_r[int];

  logic [9:0] cols_in_use = 10'd512;
  logic [9:0] rows_in_use = 10'd512;
  logic       color_on = 1'b1;
  int         err_cnt = 0;
  int         pend_cnt = 0;

  mean_item_t expected_means[$];

  assign errors_o  = err_cnt;
  assign pending_o = pend_cnt;

  function automatic mean_item_t predict_mean(op_item_t it);
    mean_item_t r;
    int         idx;
    bit [7:0]   n;
    r = '0;
    r.st = ppab_pkg::ST_OK;
    if (it.op == ppab_pkg::OP_NONE || it.col >= cols_in_use || it.row >= rows_in_use) begin
      r.st = ppab_pkg::ST_RANGE;
      return r;
    end
    idx = int'(it.row) * 512 + int'(it.col);
    n = hit_mem.exists(idx) ? hit_mem[idx] : 8'd0;
    if (it.op == ppab_pkg::OP_SET || (it.op == ppab_pkg::OP_ADD && n == 0)) begin
      sum_x[idx] = longint'($signed(it.px));
      sum_y[idx] = longint'($signed(it.py));
      sum_z[idx] = longint'($signed(it.pz));
      sum_b[idx] = color_on ? {8'd0, it.blue}  : 16'd0;
      sum_g[idx] = color_on ? {8'd0, it.green} : 16'd0;
      sum_r[idx] = color_on ? {8'd0, it.red}   : 16'd0;
      hit_mem[idx] = 8'd1;
      r.hits = 8'd1;
    end else if (it.op == ppab_pkg::OP_ADD) begin
      r.hits = n;
      if (n >= ppab_pkg::MAX_COUNT) begin
        r.st = ppab_pkg::ST_FULL;
        return r;
      end
      sum_x[idx] += longint'($signed(it.px));
      sum_y[idx] += longint'($signed(it.py));
      sum_z[idx] += longint'($signed(it.pz));
      if (color_on) begin
        sum_b[idx] += {8'd0, it.blue};
        sum_g[idx] += {8'd0, it.green};
        sum_r[idx] += {8'd0, it.red};
      end else begin
        r.st = ppab_pkg::ST_NOCOLOR;
      end
      hit_mem[idx] = n + 8'd1;
      r.hits = n + 8'd1;
    end else if (n == 0) begin
      r.st = ppab_pkg::ST_EMPTY;
    end else begin
      // signed division truncates toward zero
      r.mx = 32'(sum_x[idx] / longint'(n));
      r.my = 32'(sum_y[idx] / longint'(n));
      r.mz = 32'(sum_z[idx] / longint'(n));
      if (color_on) begin
        r.blue  = 8'(sum_b[idx] / n);
        r.green = 8'(sum_g[idx] / n);
        r.red   = 8'(sum_r[idx] / n);
      end else begin
        r.st = ppab_pkg::ST_NOCOLOR;
      end
      r.hits = n;
    end
    return r;
  endfunction

  task automatic cmp_field(string nm, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, nm, exp_v, act_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    mean_item_t e, a;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          ppab_pkg::REG_WIDTH:  cols_in_use = pwdata[9:0];
          ppab_pkg::REG_HEIGHT: rows_in_use = pwdata[9:0];
          ppab_pkg::REG_COLOR:  color_on = pwdata[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_means.push_back(predict_mean(op_item_t'(s_axis_tdata[139:0])));
      if (m_axis_tvalid && m_axis_tready) begin
        a = mean_item_t'(m_axis_tdata[130:0]);
        if (expected_means.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, a);
          err_cnt++;
        end else begin
          e = expected_means.pop_front();
          cmp_field("status", 32'(e.st), 32'(a.st));
          cmp_field("mean_x", e.mx, a.mx);
          cmp_field("mean_y", e.my, a.my);
          cmp_field("mean_z", e.mz, a.mz);
          cmp_field("mean_blue", 32'(e.blue), 32'(a.blue));
          cmp_field("mean_green", 32'(e.green), 32'(a.green));
          cmp_field("mean_red", 32'(e.red), 32'(a.red));
          cmp_field("hit_count", 32'(e.hits), 32'(a.hits));
          if (m_axis_tdata[ppab_pkg::OUT_W-1:131] !== '0) begin
            $display("%0t: fill bits, expected 0, actual %h", $time,
                     m_axis_tdata[ppab_pkg::OUT_W-1:131]);
            err_cnt++;
          end
        end
      end
      pend_cnt = expected_means.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives set, add, read and no-op items into the pixel point average buffer over
// several register settings; a scoreboard beside the block predicts and
// checks every result. Gives the verdict.
// ----------------------------------------------------------------------------
module tb;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [ppab_pkg::IN_W-1:0]  s_axis_tdata = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [ppab_pkg::OUT_W-1:0] m_axis_tdata;
  logic                       psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]                 paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;
  int                         errors, pending;
  int                         burst_left = 0;

  always #5 clk_i = ~clk_i;

  pixel_point_average_buffer u_top (.*);

  ppab_scoreboard u_scoreboard (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .psel, .penable, .pwrite,
    .paddr, .pwdata, .pready, .errors_o(errors), .pending_o(pending)
  );

  // Receiver stall pattern: switch between always ready, coin flip, mostly
  // stalled and fully stalled after each run of random length.
  int unsigned stall_mode = 0, stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 150);
    end
    stall_left--;
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 4) == 0);
      default: m_axis_tready <= 1'b0;
    endcase
  end

  // Run limit: clearing pass plus the slowest item stream, several times over.
  initial begin
    #60_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_sizes(int cols, int rows, bit color);
    reg_write(ppab_pkg::REG_WIDTH, cols);
    reg_write(ppab_pkg::REG_HEIGHT, rows);
    reg_write(ppab_pkg::REG_COLOR, {31'd0, color});
  endtask

  // Hold the item until accepted; insert a random gap between bursts.
  task automatic send_op(ppab_pkg::opcode_e op, int col, int row, logic [31:0] x,
                         logic [31:0] y, logic [31:0] z, logic [7:0] b, logic [7:0] g,
                         logic [7:0] r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, r, g, b, z, y, x, row[8:0], col[8:0], op};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Pause the sender until every expected result has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_op(int span);
    ppab_pkg::opcode_e op;
    int                w, col, row;
    w = $urandom_range(0, 99);
    op = w < 20 ? ppab_pkg::OP_SET : w < 65 ? ppab_pkg::OP_ADD :
         w < 95 ? ppab_pkg::OP_READ : ppab_pkg::OP_NONE;
    // mostly a small window so pixels collect several hits
    if ($urandom_range(0, 9) < 8) begin
      col = $urandom_range(0, span);
      row = $urandom_range(0, span);
    end else begin
      col = $urandom_range(0, 511);
      row = $urandom_range(0, 511);
    end
    send_op(op, col, row, rand_coord(), rand_coord(), rand_coord(),
            8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every operation, empty and out-of-range pixels.
    set_sizes(512, 512, 1'b1);
    send_op(ppab_pkg::OP_SET, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 8'hFF, 8'h00, 8'h80);
    send_op(ppab_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
    send_op(ppab_pkg::OP_ADD, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
            8'hFF, 8'h01, 8'h7F);
    send_op(ppab_pkg::OP_ADD, 0, 0, 32'hFFFF_0001, 32'h0001_8000, 32'h7FFF_FFFF,
            8'h00, 8'hFF, 8'h55);
    send_op(ppab_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
    send_op(ppab_pkg::OP_ADD, 5, 3, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 8'hAA, 8'h55, 8'hFF);
    send_op(ppab_pkg::OP_READ, 5, 3, 0, 0, 0, 0, 0, 0);
    send_op(ppab_pkg::OP_READ, 7, 7, 0, 0, 0, 0, 0, 0);
    send_op(ppab_pkg::OP_NONE, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            8'hFF, 8'hFF, 8'hFF);
    send_op(ppab_pkg::OP_SET, 511, 511, 32'h1234_5678, 32'hFEDC_BA98, 32'h0,
            8'h01, 8'h02, 8'h03);
    send_op(ppab_pkg::OP_READ, 511, 511, 0, 0, 0, 0, 0, 0);
    send_op(ppab_pkg::OP_SET, 0, 0, 32'h10, 32'h20, 32'h30, 8'h10, 8'h20, 8'h30);
    drain();

    // Smallest grid: only pixel (0,0) is in range.
    set_sizes(1, 1, 1'b1);
    send_op(ppab_pkg::OP_ADD, 1, 0, 32'h1, 32'h1, 32'h1, 8'h1, 8'h1, 8'h1);
    send_op(ppab_pkg::OP_READ, 0, 1, 0, 0, 0, 0, 0, 0);
    send_op(ppab_pkg::OP_ADD, 0, 0, 32'h1, 32'h2, 32'h3, 8'h4, 8'h5, 8'h6);
    send_op(ppab_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
    drain();

    // Color disabled: add keeps old color sums, set clears them.
    set_sizes(512, 512, 1'b0);
    send_op(ppab_pkg::OP_ADD, 0, 0, 32'h100, 32'h200, 32'h300, 8'hFF, 8'hFF, 8'hFF);
    send_op(ppab_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
    send_op(ppab_pkg::OP_SET, 2, 2, 32'h100, 32'h200, 32'h300, 8'hFF, 8'hFF, 8'hFF);
    drain();
    reg_write(ppab_pkg::REG_COLOR, 32'd1);
    send_op(ppab_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
    send_op(ppab_pkg::OP_READ, 2, 2, 0, 0, 0, 0, 0, 0);
    drain();

    // Random phases over several register settings.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_sizes(512, 512, 1'b1);
        1: set_sizes(8, 4, 1'b1);
        2: set_sizes(512, 512, 1'b0);
        3: set_sizes(0, 512, 1'b1);
        4: set_sizes(300, 1023, 1'b1);
        5: set_sizes($urandom_range(1, 16), $urandom_range(1, 16),
                     1'($urandom_range(0, 1)));
        default: set_sizes(512, 512, 1'b1);
      endcase
      for (int i = 0; i < 70; i++) random_op(ph == 1 ? 9 : 7);
      drain();
    end

    // Drive one pixel past its hit limit, reading it now and then.
    send_op(ppab_pkg::OP_SET, 20, 20, rand_coord(), rand_coord(), rand_coord(),
            8'($urandom), 8'($urandom), 8'($urandom));
    for (int i = 0; i < 260; i++) begin
      if (i % 16 == 0) send_op(ppab_pkg::OP_READ, 20, 20, 0, 0, 0, 0, 0, 0);
      send_op(ppab_pkg::OP_ADD, 20, 20, rand_coord(), rand_coord(), rand_coord(),
              8'($urandom), 8'($urandom), 8'($urandom));
    end
    send_op(ppab_pkg::OP_READ, 20, 20, 0, 0, 0, 0, 0, 0);
    drain();
    repeat (100) @(posedge clk_i);

    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
